FILE: design/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types, constants and helpers for the video region adjust block.
// ----------------------------------------------------------------------------
package vra_pkg;

  localparam int COORD_W  = 13;
  localparam int INNER_W  = 12;
  localparam int CFG_IDX_W = 2;

  // signed work width, wide enough for 3 * 8191 plus one size step
  typedef logic signed [15:0] sval_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [INNER_W-1:0] inner_t;

  localparam sval_t MIN_SIZE   = 16'sd16;
  localparam sval_t ALIGN_MASK = 16'sd15;

  localparam int BTN_W     = 7;
  localparam int BTN_RIGHT = 0;
  localparam int BTN_LEFT  = 1;
  localparam int BTN_UP    = 2;
  localparam int BTN_DOWN  = 3;
  localparam int BTN_R1    = 4;
  localparam int BTN_R2    = 5;
  localparam int BTN_L2    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
    inner_t ix;
    inner_t iy;
    coord_t ox;
    coord_t oy;
  } region_t;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t width;
    coord_t height;
  } mask_t;

  function automatic sval_t ext13(coord_t v);
    return sval_t'({3'b000, v});
  endfunction

  function automatic sval_t ext12(inner_t v);
    return sval_t'({4'b0000, v});
  endfunction

  // lower bound wins when hi < lo
  function automatic sval_t sat(sval_t v, sval_t lo, sval_t hi);
    sval_t r;
    r = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r;
  endfunction

endpackage

FILE: design/vra_axis_resize.sv
// ----------------------------------------------------------------------------
// vra_axis_resize
// One axis of a centered resize: new aligned size and unclamped new position.
// ----------------------------------------------------------------------------
module vra_axis_resize #(
  parameter int SIZE_STEP = 16
) (
  input  vra_pkg::coord_t pos,
  input  vra_pkg::coord_t size,
  input  logic            grow,
  input  vra_pkg::coord_t limit,
  output vra_pkg::coord_t new_size,
  output vra_pkg::sval_t  new_pos
);

  localparam vra_pkg::sval_t STEP = vra_pkg::sval_t'(SIZE_STEP);

  vra_pkg::sval_t stepped;
  vra_pkg::sval_t aligned;
  vra_pkg::sval_t lim_al;
  vra_pkg::sval_t sized;
  vra_pkg::sval_t twice_ctr;

  always_comb begin
    stepped = grow ? vra_pkg::ext13(size) + STEP : vra_pkg::ext13(size) - STEP;
    aligned = stepped & ~vra_pkg::ALIGN_MASK;
    lim_al  = vra_pkg::ext13(limit) & ~vra_pkg::ALIGN_MASK;
    if (stepped < vra_pkg::MIN_SIZE) begin
      sized = vra_pkg::MIN_SIZE;
    end else begin
      sized = vra_pkg::sat(aligned, vra_pkg::MIN_SIZE, lim_al);
    end
    new_size  = sized[vra_pkg::COORD_W-1:0];
    twice_ctr = (vra_pkg::ext13(pos) <<< 1) + vra_pkg::ext13(size) - sized;
    // negative values are clamped to zero later, so the shift rounding is moot
    new_pos   = twice_ctr >>> 1;
  end

endmodule

FILE: design/vra_step.sv
// ----------------------------------------------------------------------------
// vra_step
// Next region state from one button mask, final clamp and the matte rectangle.
// ----------------------------------------------------------------------------
module vra_step #(
  parameter int SIZE_STEP = 16
) (
  input  vra_pkg::region_t          cur,
  input  logic [vra_pkg::BTN_W-1:0] buttons,
  input  vra_pkg::coord_t           frame_width,
  input  vra_pkg::coord_t           frame_height,
  output vra_pkg::region_t          nxt,
  output vra_pkg::mask_t            mask
);

  vra_pkg::coord_t rw_size;
  vra_pkg::sval_t  rw_pos;
  vra_pkg::coord_t rh_size;
  vra_pkg::sval_t  rh_pos;

  vra_axis_resize #(.SIZE_STEP(SIZE_STEP)) u_resize_x (
    .pos      (cur.x),
    .size     (cur.w),
    .grow     (buttons[vra_pkg::BTN_RIGHT]),
    .limit    (frame_width),
    .new_size (rw_size),
    .new_pos  (rw_pos)
  );

  vra_axis_resize #(.SIZE_STEP(SIZE_STEP)) u_resize_y (
    .pos      (cur.y),
    .size     (cur.h),
    .grow     (buttons[vra_pkg::BTN_UP]),
    .limit    (frame_height),
    .new_size (rh_size),
    .new_pos  (rh_pos)
  );

  vra_pkg::sval_t hd, vd;
  vra_pkg::sval_t x, y, w, h, ix, iy, ox, oy;
  vra_pkg::sval_t cw, ch;
  vra_pkg::sval_t cx, cy, cix, ciy, cox, coy;
  vra_pkg::sval_t l, t, rr, bt;

  always_comb begin
    hd = vra_pkg::sval_t'(buttons[vra_pkg::BTN_RIGHT])
       - vra_pkg::sval_t'(buttons[vra_pkg::BTN_LEFT]);
    vd = vra_pkg::sval_t'(buttons[vra_pkg::BTN_UP])
       - vra_pkg::sval_t'(buttons[vra_pkg::BTN_DOWN]);
    cw = vra_pkg::ext13(frame_width);
    ch = vra_pkg::ext13(frame_height);
    x  = vra_pkg::ext13(cur.x);
    y  = vra_pkg::ext13(cur.y);
    w  = vra_pkg::ext13(cur.w);
    h  = vra_pkg::ext13(cur.h);
    ix = vra_pkg::ext12(cur.ix);
    iy = vra_pkg::ext12(cur.iy);
    ox = vra_pkg::ext13(cur.ox);
    oy = vra_pkg::ext13(cur.oy);

    if (buttons[vra_pkg::BTN_R1]) begin
      x = x + hd;
      y = y - vd;
    end else if (buttons[vra_pkg::BTN_R2]) begin
      ix = ix + hd;
      iy = iy + hd - vd;
    end else if (buttons[vra_pkg::BTN_L2]) begin
      ox = ox - hd;
      oy = oy - hd + vd;
    end else begin
      if (hd != 16'sd0) begin
        w = vra_pkg::ext13(rw_size);
        x = rw_pos;
      end
      if (vd != 16'sd0) begin
        h = vra_pkg::ext13(rh_size);
        y = rh_pos;
      end
    end

    cx  = vra_pkg::sat(x, 16'sd0, cw - w);
    cy  = vra_pkg::sat(y, 16'sd0, ch - h);
    cix = vra_pkg::sat(ix, 16'sd0, w >>> 1);
    ciy = vra_pkg::sat(iy, 16'sd0, h >>> 1);
    cox = vra_pkg::sat(ox, 16'sd0, cw);
    coy = vra_pkg::sat(oy, 16'sd0, ch);

    l  = vra_pkg::sat(cx - cox, 16'sd0, cw);
    t  = vra_pkg::sat(cy - coy, 16'sd0, ch);
    rr = vra_pkg::sat(cx + w + cox, 16'sd0, cw);
    bt = vra_pkg::sat(cy + h + coy, 16'sd0, ch);

    nxt.x  = cx[vra_pkg::COORD_W-1:0];
    nxt.y  = cy[vra_pkg::COORD_W-1:0];
    nxt.w  = w[vra_pkg::COORD_W-1:0];
    nxt.h  = h[vra_pkg::COORD_W-1:0];
    nxt.ix = cix[vra_pkg::INNER_W-1:0];
    nxt.iy = ciy[vra_pkg::INNER_W-1:0];
    nxt.ox = cox[vra_pkg::COORD_W-1:0];
    nxt.oy = coy[vra_pkg::COORD_W-1:0];

    mask.left   = l[vra_pkg::COORD_W-1:0];
    mask.top    = t[vra_pkg::COORD_W-1:0];
    mask.width  = 13'(rr - l);
    mask.height = 13'(bt - t);
  end

endmodule

FILE: design/video_region_adjust_with_matte.sv
// ----------------------------------------------------------------------------
// video_region_adjust_with_matte
// Video window editor: moves, resizes and mattes a window on a canvas per
// button mask and reports the window with its clamped suppression rectangle.
// ----------------------------------------------------------------------------
// flow: a button mask is taken into the input register, then stepped into
// the result register; throughput: one button mask per cycle unless stalled
// by result_stall; the region state loops through combinational step logic
// reset: window 16x16 at the origin, mattes zero, canvas 640x480
// ----------------------------------------------------------------------------
module video_region_adjust_with_matte #(
  parameter int SIZE_STEP = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [vra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vra_pkg::COORD_W-1:0]   cfg_data,
  input  logic                          buttons_valid,
  output logic                          buttons_stall,
  input  logic [vra_pkg::BTN_W-1:0]     buttons,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [12:0]                   win_x,
  output logic [12:0]                   win_y,
  output logic [12:0]                   win_width,
  output logic [12:0]                   win_height,
  output logic [11:0]                   inner_margin_x,
  output logic [11:0]                   inner_margin_y,
  output logic [12:0]                   outer_margin_x,
  output logic [12:0]                   outer_margin_y,
  output logic [12:0]                   mask_left,
  output logic [12:0]                   mask_top,
  output logic [12:0]                   mask_width,
  output logic [12:0]                   mask_height
);

  vra_pkg::coord_t               frame_width;
  vra_pkg::coord_t               frame_height;
  vra_pkg::region_t              region;
  vra_pkg::region_t              region_next;
  vra_pkg::mask_t                mask_next;
  logic                          held_valid;
  logic [vra_pkg::BTN_W-1:0]     held_buttons;
  logic                          advance;

  assign advance       = !result_valid || !result_stall;
  assign buttons_stall = held_valid && !advance;

  vra_step #(.SIZE_STEP(SIZE_STEP)) u_step (
    .cur          (region),
    .buttons      (held_buttons),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .nxt          (region_next),
    .mask         (mask_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 13'd640;
      frame_height <= 13'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        vra_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        vra_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!buttons_stall) begin
      held_valid <= buttons_valid;
    end
    if (!buttons_stall && buttons_valid) begin
      held_buttons <= buttons;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      region       <= '{x: 13'd0, y: 13'd0, w: 13'd16, h: 13'd16,
                        ix: 12'd0, iy: 12'd0, ox: 13'd0, oy: 13'd0};
    end else if (advance) begin
      result_valid <= held_valid;
      if (held_valid) begin
        region <= region_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      mask_left   <= mask_next.left;
      mask_top    <= mask_next.top;
      mask_width  <= mask_next.width;
      mask_height <= mask_next.height;
    end
  end

  assign win_x          = region.x;
  assign win_y          = region.y;
  assign win_width      = region.w;
  assign win_height     = region.h;
  assign inner_margin_x = region.ix;
  assign inner_margin_y = region.iy;
  assign outer_margin_x = region.ox;
  assign outer_margin_y = region.oy;

endmodule
